// File: hdl/slew_limiter_delta_smoother_unit_macros.svh
`ifndef SLEW_LIMITER_DELTA_SMOOTHER_UNIT_MACROS_SVH
`define SLEW_LIMITER_DELTA_SMOOTHER_UNIT_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define SLDS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define SLDS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/slds_pkg.sv
package slds_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int CHANNELS      = 2;
    localparam int CH_BITS       = 1;
    localparam int MAX_WINDOW    = 4096;
    localparam int POS_BITS      = 12;
    localparam int ADDR_BITS     = CH_BITS + POS_BITS;
    localparam int RING_DEPTH    = CHANNELS * MAX_WINDOW;
    localparam int DELTA_BITS    = SAMPLE_BITS + 1;
    localparam int SUM_BITS      = 37;
    localparam int WIN_BITS      = 13;
    localparam int STEP_BITS     = 23;
    localparam int GAIN_BITS     = 16;
    localparam int GAIN_FRAC     = 13;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 23;
    localparam int DIV_STEPS     = SUM_BITS;
    localparam int DIV_CNT_BITS  = 6;
    localparam int Y_BITS        = SUM_BITS;
    localparam int SPLIT         = 20;
    localparam int PLO_BITS      = SPLIT + GAIN_BITS;
    localparam int PHI_BITS      = (Y_BITS - SPLIT) + GAIN_BITS + 1;
    localparam int ACC_BITS      = PHI_BITS + SPLIT + 1;
    localparam int SHR_BITS      = ACC_BITS - GAIN_FRAC;

    localparam logic [WIN_BITS-1:0] WIN_MIN = WIN_BITS'(2);
    localparam logic [WIN_BITS-1:0] WIN_MAX = WIN_BITS'(MAX_WINDOW);

    localparam logic [STEP_BITS-1:0] RST_MAX_STEP = STEP_BITS'(8388);
    localparam logic [WIN_BITS-1:0]  RST_WINDOW   = WIN_BITS'(2);
    localparam logic [GAIN_BITS-1:0] RST_GAIN     = GAIN_BITS'(8192);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE      = 2'd0,
        CFG_MAX_STEP  = 2'd1,
        CFG_WINDOW    = 2'd2,
        CFG_GAIN      = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SLEW,
        ST_UPDATE,
        ST_DIVIDE,
        ST_SUM,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ROUND,
        ST_OUT
    } state_t;

endpackage

// File: hdl/slew_limiter_delta_smoother_unit.sv
// Slew mode runs SLEW, MUL_LO, MUL_HI, ROUND, OUT; smoothing mode runs UPDATE, DIVIDE, SUM,
// MUL_LO, MUL_HI, ROUND, OUT, with a bit-serial divider (37 steps, one quotient bit a cycle).
// A new sample is accepted only after the last result is loaded into the output register.
// Reset: synchronous, active low; control and config registers return to their defaults and
// the delta ring is cleared, one entry a cycle over all 8192 entries, with s_ready held low.
module slew_limiter_delta_smoother_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [slds_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [slds_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [slds_pkg::CH_BITS-1:0]        s_channel,
    input  logic signed [slds_pkg::SAMPLE_BITS-1:0] s_sample_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [slds_pkg::SAMPLE_BITS-1:0] m_sample_out
);
    import slds_pkg::*;

    `include "slew_limiter_delta_smoother_unit_macros.svh"

    state_t state_reg, state_next;

    logic                   mode_reg, mode_next;
    logic [STEP_BITS-1:0]   max_step_reg, max_step_next;
    logic [WIN_BITS-1:0]    win_len_reg, win_len_next;
    logic [GAIN_BITS-1:0]   gain_reg, gain_next;

    logic signed [SAMPLE_BITS-1:0] prev_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] prev_next [CHANNELS];
    logic signed [SUM_BITS-1:0]    sum_reg [CHANNELS];
    logic signed [SUM_BITS-1:0]    sum_next [CHANNELS];
    logic [POS_BITS-1:0]           pos_reg [CHANNELS];
    logic [POS_BITS-1:0]           pos_next [CHANNELS];

    logic [ADDR_BITS-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [CH_BITS-1:0]            ch_reg, ch_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic signed [SAMPLE_BITS-1:0] prev_old_reg, prev_old_next;
    logic [WIN_BITS-1:0]           win_reg, win_next;
    logic [POS_BITS-1:0]           pos_cur_reg, pos_cur_next;

    logic [SUM_BITS-1:0]           num_reg, num_next;
    logic [WIN_BITS-1:0]           rem_reg, rem_next;
    logic                          neg_reg, neg_next;
    logic [DIV_CNT_BITS-1:0]       div_cnt_reg, div_cnt_next;

    logic signed [Y_BITS-1:0]      y_reg, y_next;
    logic [PLO_BITS-1:0]           plo_reg, plo_next;
    logic signed [PHI_BITS-1:0]    phi_reg, phi_next;
    logic signed [SAMPLE_BITS-1:0] res_reg, res_next;

    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] m_data_reg, m_data_next;

    logic [DELTA_BITS-1:0] ring_mem [RING_DEPTH];
    logic [DELTA_BITS-1:0] rd_data_reg;
    logic                  mem_we;
    logic                  mem_re;
    logic [ADDR_BITS-1:0]  mem_waddr;
    logic [ADDR_BITS-1:0]  mem_raddr;
    logic [DELTA_BITS-1:0] mem_wdata;

    logic                  in_xfer;
    logic                  out_load;
    logic [WIN_BITS-1:0]   win_eff;
    logic [POS_BITS-1:0]   pos_sel;
    logic [POS_BITS-1:0]   pos_eff;

    logic signed [DELTA_BITS-1:0] delta_w;
    logic signed [DELTA_BITS-1:0] ms_w;
    logic signed [DELTA_BITS-1:0] slew_y;
    logic signed [SUM_BITS-1:0]   sum_new;
    logic [WIN_BITS-1:0]          pos_inc;
    logic [WIN_BITS:0]            trial;
    logic signed [SUM_BITS:0]     q_s;
    logic signed [SUM_BITS:0]     y_full;
    logic signed [ACC_BITS-1:0]   acc;
    logic signed [SHR_BITS-1:0]   shr;

    assign in_xfer  = s_valid && s_ready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_data_reg;

    // window clamp and ring position at transfer time
    always_comb begin
        if (win_len_reg < WIN_MIN) begin
            win_eff = WIN_MIN;
        end else if (win_len_reg > WIN_MAX) begin
            win_eff = WIN_MAX;
        end else begin
            win_eff = win_len_reg;
        end
        pos_sel = pos_reg[s_channel];
        pos_eff = ({1'b0, pos_sel} >= win_eff) ? '0 : pos_sel;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == ADDR_BITS'(RING_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = mode_reg ? ST_UPDATE : ST_SLEW;
                end
            end
            ST_SLEW:   state_next = ST_MUL_LO;
            ST_UPDATE: state_next = ST_DIVIDE;
            ST_DIVIDE: begin
                if (div_cnt_reg == '0) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:    state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    // handshake and ring port controls
    always_comb begin
        s_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = {ch_reg, pos_cur_reg};
        mem_wdata = delta_w;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            ST_IDLE:   s_ready = 1'b1;
            ST_UPDATE: mem_we  = 1'b1;
            default: begin
                s_ready = 1'b0;
                mem_we  = 1'b0;
            end
        endcase
        mem_re    = in_xfer && mode_reg;
        mem_raddr = {s_channel, pos_eff};
    end

    // datapath arithmetic
    always_comb begin
        delta_w = {x_reg[SAMPLE_BITS-1], x_reg} - {prev_old_reg[SAMPLE_BITS-1], prev_old_reg};
        ms_w    = $signed({2'b00, max_step_reg});
        if (delta_w > ms_w) begin
            slew_y = {prev_old_reg[SAMPLE_BITS-1], prev_old_reg} + ms_w;
        end else if (delta_w < -ms_w) begin
            slew_y = {prev_old_reg[SAMPLE_BITS-1], prev_old_reg} - ms_w;
        end else begin
            slew_y = {x_reg[SAMPLE_BITS-1], x_reg};
        end
        sum_new = sum_reg[ch_reg] + SUM_BITS'(delta_w) - SUM_BITS'($signed(rd_data_reg));
        pos_inc = {1'b0, pos_cur_reg} + WIN_BITS'(1);
        trial   = {rem_reg, num_reg[SUM_BITS-1]};
        q_s     = $signed({1'b0, num_reg});
        if (neg_reg) begin
            q_s = -q_s;
        end
        y_full = q_s + (SUM_BITS+1)'(prev_old_reg);
        acc    = (ACC_BITS'(phi_reg) <<< SPLIT) + $signed({1'b0, plo_reg})
                 + ACC_BITS'(1 << (GAIN_FRAC - 1));
        shr    = acc[ACC_BITS-1:GAIN_FRAC];
    end

    // register next values
    always_comb begin
        mode_next     = mode_reg;
        max_step_next = max_step_reg;
        win_len_next  = win_len_reg;
        gain_next     = gain_reg;
        prev_next     = prev_reg;
        sum_next      = sum_reg;
        pos_next      = pos_reg;
        clr_cnt_next  = clr_cnt_reg;
        ch_next       = ch_reg;
        x_next        = x_reg;
        prev_old_next = prev_old_reg;
        win_next      = win_reg;
        pos_cur_next  = pos_cur_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        div_cnt_next  = div_cnt_reg;
        y_next        = y_reg;
        plo_next      = plo_reg;
        phi_next      = phi_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_MODE:     mode_next     = cfg_wdata[0];
                CFG_MAX_STEP: max_step_next = cfg_wdata[STEP_BITS-1:0];
                CFG_WINDOW:   win_len_next  = cfg_wdata[WIN_BITS-1:0];
                CFG_GAIN:     gain_next     = cfg_wdata[GAIN_BITS-1:0];
                default:      mode_next     = mode_reg;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: clr_cnt_next = clr_cnt_reg + ADDR_BITS'(1);
            ST_IDLE: begin
                if (in_xfer) begin
                    ch_next       = s_channel;
                    x_next        = s_sample_in;
                    prev_old_next = prev_reg[s_channel];
                    win_next      = win_eff;
                    pos_cur_next  = pos_eff;
                end
            end
            ST_SLEW: begin
                prev_next[ch_reg] = slew_y[SAMPLE_BITS-1:0];
                y_next            = Y_BITS'(slew_y);
            end
            ST_UPDATE: begin
                sum_next[ch_reg]  = sum_new;
                prev_next[ch_reg] = x_reg;
                pos_next[ch_reg]  = (pos_inc >= win_reg) ? '0 : pos_inc[POS_BITS-1:0];
                neg_next          = sum_new[SUM_BITS-1];
                num_next          = sum_new[SUM_BITS-1] ? SUM_BITS'(-sum_new) : sum_new;
                rem_next          = '0;
                div_cnt_next      = DIV_CNT_BITS'(DIV_STEPS - 1);
            end
            ST_DIVIDE: begin
                if (trial >= {1'b0, win_reg}) begin
                    rem_next = WIN_BITS'(trial - {1'b0, win_reg});
                    num_next = {num_reg[SUM_BITS-2:0], 1'b1};
                end else begin
                    rem_next = trial[WIN_BITS-1:0];
                    num_next = {num_reg[SUM_BITS-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - DIV_CNT_BITS'(1);
            end
            ST_SUM:    y_next   = y_full[Y_BITS-1:0];
            ST_MUL_LO: plo_next = y_reg[SPLIT-1:0] * gain_reg;
            ST_MUL_HI: phi_next = $signed(y_reg[Y_BITS-1:SPLIT]) * $signed({1'b0, gain_reg});
            ST_ROUND: begin
                if (shr[SHR_BITS-1] && !(&shr[SHR_BITS-2:SAMPLE_BITS-1])) begin
                    res_next = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                end else if (!shr[SHR_BITS-1] && (|shr[SHR_BITS-2:SAMPLE_BITS-1])) begin
                    res_next = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                end else begin
                    res_next = shr[SAMPLE_BITS-1:0];
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: clr_cnt_next = clr_cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= ring_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            mode_reg     <= 1'b0;
            max_step_reg <= RST_MAX_STEP;
            win_len_reg  <= RST_WINDOW;
            gain_reg     <= RST_GAIN;
            clr_cnt_reg  <= '0;
            div_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                prev_reg[i] <= '0;
                sum_reg[i]  <= '0;
                pos_reg[i]  <= '0;
            end
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            max_step_reg <= max_step_next;
            win_len_reg  <= win_len_next;
            gain_reg     <= gain_next;
            clr_cnt_reg  <= clr_cnt_next;
            div_cnt_reg  <= div_cnt_next;
            m_valid_reg  <= m_valid_next;
            prev_reg     <= prev_next;
            sum_reg      <= sum_next;
            pos_reg      <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg       <= ch_next;
        x_reg        <= x_next;
        prev_old_reg <= prev_old_next;
        win_reg      <= win_next;
        pos_cur_reg  <= pos_cur_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        y_reg        <= y_next;
        plo_reg      <= plo_next;
        phi_reg      <= phi_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    `SLDS_ASSERT_IMP(a_clear_blocks_input, state_reg == ST_CLEAR, !s_ready, "transfer during ring clear")
    `SLDS_ASSERT_IMP(a_ring_write_phase, mem_we, (state_reg == ST_CLEAR || state_reg == ST_UPDATE), "ring written outside clear or update")
    `SLDS_ASSERT_NXT(a_divide_ends, (state_reg == ST_DIVIDE && div_cnt_reg == '0), state_reg == ST_SUM, "divider did not finish")
    `SLDS_ASSERT_NXT(a_result_loaded, out_load, (m_valid && state_reg == ST_IDLE), "result not presented")

endmodule
